FILE: sv/sorted_group_merge_join_macros.svh
// Assertion macros shared by the merge join RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SORTED_GROUP_MERGE_JOIN_MACROS_SVH
`define SORTED_GROUP_MERGE_JOIN_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SGMJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SGMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sgmj_pkg.sv
// Types and codes for the sorted group merge join.
// No dependencies; used by sgmj_list_mem and sorted_group_merge_join.
package sgmj_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_APPEND_A = 2'd1,
    KIND_APPEND_B = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_STEP = 1'b1
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [16:0]        range_begin;
    logic [16:0]        range_end;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] match_value;
    logic [16:0]        begin_a;
    logic [16:0]        end_a;
    logic [16:0]        begin_b;
    logic [16:0]        end_b;
  } out_item_t;

  // One list entry as stored in memory.
  typedef struct packed {
    logic signed [31:0] value;
    logic [16:0]        range_end;
    logic [16:0]        range_begin;
  } entry_t;

endpackage

FILE: sv/sgmj_list_mem.sv
// Single-port-write, single-port-read list memory with registered read data.
// Depends on sgmj_pkg for the entry type.
module sgmj_list_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  sgmj_pkg::entry_t    wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output sgmj_pkg::entry_t    rd_data
);
  import sgmj_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/sorted_group_merge_join.sv
// Top level of the sorted group merge join: list memories, cursors, merge FSM.
// Depends on sgmj_pkg, sgmj_list_mem and sorted_group_merge_join_macros.svh.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | sgmj_pkg::in_item_t
//   out     | output    | out_valid/out_stall| sgmj_pkg::out_item_t
//
// Clear and append items are handled in the idle state.
// A query moves the FSM to the step state, where the cursors step past entries; each
// step is one read of both list memories (registered read data).
// The result waits in the output register; input is taken again once the query ends.
// A finished query holds in its last step while the output register is full and stalled.
// Reset clears counts, cursors, the output valid flag and the FSM; the memories need no clearing pass.
module sorted_group_merge_join #(
  parameter int LIST_DEPTH = 4096,
  parameter int MAX_ROWS   = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sgmj_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sgmj_pkg::out_item_t  out_item
);
  import sgmj_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [24:0] MAX_ROWS_C = 25'(MAX_ROWS);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_a_r, count_a_nxt;
  logic [CNT_W-1:0]  count_b_r, count_b_nxt;
  logic [CNT_W-1:0]  cursor_a_r, cursor_a_nxt;
  logic [CNT_W-1:0]  cursor_b_r, cursor_b_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_acc;
  logic              out_free;
  logic              wr_a, wr_b;
  logic              step_done;
  logic              a_end, b_end;
  entry_t            wr_entry;
  entry_t            rd_a, rd_b;
  logic [16:0]       begin_clamped, end_clamped;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Saturate offsets to the row limit on the way in.
  assign begin_clamped = ({8'd0, in_item.range_begin} > MAX_ROWS_C) ?
                         MAX_ROWS_C[16:0] : in_item.range_begin;
  assign end_clamped   = ({8'd0, in_item.range_end} > MAX_ROWS_C) ?
                         MAX_ROWS_C[16:0] : in_item.range_end;

  always_comb begin
    wr_entry.value       = in_item.value;
    wr_entry.range_begin = begin_clamped;
    wr_entry.range_end   = end_clamped;
  end

  sgmj_list_mem #(.DEPTH(LIST_DEPTH)) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (cursor_a_nxt[IDX_W-1:0]),
    .rd_data (rd_a)
  );

  sgmj_list_mem #(.DEPTH(LIST_DEPTH)) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (cursor_b_nxt[IDX_W-1:0]),
    .rd_data (rd_b)
  );

  assign a_end = (cursor_a_r >= count_a_r);
  assign b_end = (cursor_b_r >= count_b_r);

  // A step ends the query on exhaustion or on a match, once the output slot is free.
  assign step_done = (state_r == ST_STEP) && out_free &&
                     (a_end || b_end || (rd_a.value == rd_b.value));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_item.kind == KIND_QUERY) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    cursor_a_nxt  = cursor_a_r;
    cursor_b_nxt  = cursor_b_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item.kind)
            KIND_CLEAR: begin
              count_a_nxt  = '0;
              count_b_nxt  = '0;
              cursor_a_nxt = '0;
              cursor_b_nxt = '0;
            end
            KIND_APPEND_A: begin
              if (count_a_r < DEPTH_C) begin
                wr_a        = 1'b1;
                count_a_nxt = count_a_r + CNT_W'(1);
              end
            end
            KIND_APPEND_B: begin
              if (count_b_r < DEPTH_C) begin
                wr_b        = 1'b1;
                count_b_nxt = count_b_r + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        if (a_end || b_end) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end
        end else if (rd_a.value < rd_b.value) begin
          cursor_a_nxt = cursor_a_r + CNT_W'(1);
        end else if (rd_b.value < rd_a.value) begin
          cursor_b_nxt = cursor_b_r + CNT_W'(1);
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.found       = 1'b1;
          out_item_nxt.match_value = rd_a.value;
          out_item_nxt.begin_a     = rd_a.range_begin;
          out_item_nxt.end_a       = rd_a.range_end;
          out_item_nxt.begin_b     = rd_b.range_begin;
          out_item_nxt.end_b       = rd_b.range_end;
          cursor_a_nxt             = cursor_a_r + CNT_W'(1);
          cursor_b_nxt             = cursor_b_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      cursor_a_r  <= '0;
      cursor_b_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      cursor_a_r  <= cursor_a_nxt;
      cursor_b_r  <= cursor_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

`include "sorted_group_merge_join_macros.svh"

  `SGMJ_ASSERT_NOW(a_cursor_a_bound, 1'b1, cursor_a_r <= count_a_r, "cursor A past count A")
  `SGMJ_ASSERT_NOW(a_cursor_b_bound, 1'b1, cursor_b_r <= count_b_r, "cursor B past count B")
  `SGMJ_ASSERT_NOW(a_count_a_bound, 1'b1, count_a_r <= DEPTH_C, "count A above depth")
  `SGMJ_ASSERT_NEXT(a_query_steps, in_acc && in_item.kind == KIND_QUERY, state_r == ST_STEP, "query did not start stepping")
  `SGMJ_ASSERT_NOW(a_notfound_zero, out_valid_r && !out_item_r.found, out_item_r.match_value == 32'sd0 && out_item_r.begin_a == 17'd0, "not-found item carries data")

endmodule
